/* hw/rtl/npcs_pkg.sv */
package npcs_pkg;

  // Kind of work that the front hands to the back
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  // Operation codes on the operation port
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned FULL_LEVEL = 255;
  localparam int unsigned SQ_W     = 2 * LEVEL_W;   // one squared difference
  localparam int unsigned RB_W     = SQ_W + 1;      // red + blue squares
  localparam int unsigned TOTAL_W  = SQ_W + 2;      // all three squares
  localparam int unsigned COUNT_W  = 9;             // color_count register

  // Classified item. For a load the colors are the entry, for a query the
  // scaled cell levels.
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         slot;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } back_state_e;

endpackage

/* hw/rtl/npcs_ram.sv */
module npcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/npcs_front.sv */
module npcs_front
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned RED_CELLS     = 32,
  parameter int unsigned GREEN_CELLS   = 64,
  parameter int unsigned BLUE_CELLS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  input  logic [4:0]  cell_red_i,
  input  logic [5:0]  cell_green_i,
  input  logic [3:0]  cell_blue_i,
  input  logic        pop_i,
  output queue_head_t head_o
);

  localparam int unsigned QDEPTH = 2;

  // Cell to level tables; indexes past the last cell read full level, which
  // also does the clamping.
  logic [LEVEL_W-1:0] red_lut   [256];
  logic [LEVEL_W-1:0] green_lut [256];
  logic [LEVEL_W-1:0] blue_lut  [256];

  for (genvar g = 0; g < 256; g++) begin : g_lut
    localparam int unsigned RV = (g >= RED_CELLS - 1) ? FULL_LEVEL :
                                 (FULL_LEVEL * g) / (RED_CELLS - 1);
    localparam int unsigned GV = (g >= GREEN_CELLS - 1) ? FULL_LEVEL :
                                 (FULL_LEVEL * g) / (GREEN_CELLS - 1);
    localparam int unsigned BV = (g >= BLUE_CELLS - 1) ? FULL_LEVEL :
                                 (FULL_LEVEL * g) / (BLUE_CELLS - 1);
    assign red_lut[g]   = LEVEL_W'(RV);
    assign green_lut[g] = LEVEL_W'(GV);
    assign blue_lut[g]  = LEVEL_W'(BV);
  end

  item_t item_d;
  logic  in_range;
  logic  push;

  assign in_range = {1'b0, entry_index_i} < 9'(PALETTE_DEPTH);

  always_comb begin
    item_d.slot = entry_index_i;
    if (operation_i == OP_QUERY) begin
      item_d.kind  = KIND_QUERY;
      item_d.red   = red_lut[8'(cell_red_i)];
      item_d.green = green_lut[8'(cell_green_i)];
      item_d.blue  = blue_lut[8'(cell_blue_i)];
    end else begin
      item_d.kind  = KIND_LOAD;
      item_d.red   = entry_red_i;
      item_d.green = entry_green_i;
      item_d.blue  = entry_blue_i;
    end
  end

  // Two-entry queue. Out-of-range loads are dropped here.
  item_t      mem_q [QDEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign busy_o = (cnt_q == 2'(QDEPTH));
  assign push   = start_i && !busy_o && ((operation_i == OP_QUERY) || in_range);
  assign pop    = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rptr_q];

endmodule

/* hw/rtl/npcs_back.sv */
module npcs_back
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned BIN_COUNT     = 16,
  parameter int unsigned BIN_SHIFT     = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  queue_head_t        head_i,
  output logic               pop_o,
  input  logic [COUNT_W-1:0] color_count_i,
  output logic               done_o,
  output logic [7:0]         nearest_index_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  back_state_e state_q, state_d;

  logic [COUNT_W-1:0] n_q, n_d;
  logic [COUNT_W-1:0] addr_q, addr_d;
  logic [LEVEL_W-1:0] qr_q, qg_q, qb_q;

  logic [COUNT_W-1:0] count_lim;
  logic               is_load, is_query;
  logic               issue, issue_last;

  assign count_lim = (color_count_i > COUNT_W'(PALETTE_DEPTH)) ?
                     COUNT_W'(PALETTE_DEPTH) : color_count_i;

  assign pop_o    = (state_q == ST_IDLE) && head_i.valid;
  assign is_load  = pop_o && (head_i.item.kind == KIND_LOAD);
  assign is_query = pop_o && (head_i.item.kind == KIND_QUERY);

  assign issue      = (state_q == ST_SCAN);
  assign issue_last = issue && (addr_q == n_q - COUNT_W'(1));

  // Palette memory
  logic [3*LEVEL_W-1:0] rdata;

  npcs_ram #(
    .WIDTH (3 * LEVEL_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (is_load),
    .waddr_i (head_i.item.slot[AW-1:0]),
    .wdata_i ({head_i.item.red, head_i.item.green, head_i.item.blue}),
    .re_i    (issue),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Stage 1: read data arrives
  logic          v1_q, last1_q;
  logic [AW-1:0] idx1_q;

  // Stage 2: squared differences
  logic               v2_q, last2_q;
  logic [AW-1:0]      idx2_q;
  logic [RB_W-1:0]    rb_q;
  logic [SQ_W-1:0]    g2_q;

  function automatic logic [SQ_W-1:0] sq_diff(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b);
    logic [LEVEL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic [SQ_W-1:0] r2, b2, g2;
  assign r2 = sq_diff(rdata[3*LEVEL_W-1:2*LEVEL_W], qr_q);
  assign g2 = sq_diff(rdata[2*LEVEL_W-1:LEVEL_W], qg_q);
  assign b2 = sq_diff(rdata[LEVEL_W-1:0], qb_q);

  // Stage 3: compare against running best
  logic [TOTAL_W-1:0] total;
  logic [RB_W-1:0]    bin_wide;
  logic [BW-1:0]      bin;
  logic               better;

  logic               have_q;
  logic [TOTAL_W-1:0] best_dist_q;
  logic [BW-1:0]      best_bin_q;
  logic [AW-1:0]      best_idx_q;

  assign total    = TOTAL_W'(rb_q) + TOTAL_W'(g2_q);
  assign bin_wide = rb_q >> BIN_SHIFT;
  assign bin      = (bin_wide > RB_W'(BIN_COUNT - 1)) ? BW'(BIN_COUNT - 1) :
                    bin_wide[BW-1:0];
  assign better   = !have_q || (total < best_dist_q) ||
                    ((total == best_dist_q) && (bin < best_bin_q));

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    addr_d  = addr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_query && (count_lim != '0)) begin
          n_d     = count_lim;
          addr_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + COUNT_W'(1);
        if (issue_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (v2_q && last2_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      addr_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      have_q  <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      addr_q  <= addr_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      done_o  <= 1'b0;
      if (is_query) begin
        have_q <= 1'b0;
        if (count_lim == '0) begin
          done_o <= 1'b1;
        end
      end else if (v2_q) begin
        have_q <= 1'b1;
        if (last2_q) begin
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      qr_q <= head_i.item.red;
      qg_q <= head_i.item.green;
      qb_q <= head_i.item.blue;
      if (count_lim == '0) begin
        nearest_index_o <= '0;
      end
    end
    idx1_q  <= addr_q[AW-1:0];
    last1_q <= issue_last;
    idx2_q  <= idx1_q;
    last2_q <= last1_q;
    rb_q    <= RB_W'(r2) + RB_W'(b2);
    g2_q    <= g2;
    if (v2_q && better) begin
      best_dist_q <= total;
      best_bin_q  <= bin;
      best_idx_q  <= idx2_q;
    end
    if (v2_q && last2_q) begin
      nearest_index_o <= better ? 8'(idx2_q) : 8'(best_idx_q);
    end
  end

endmodule

/* hw/rtl/nearest_palette_color_search.sv */
// Channel   Direction  Signals                                  Transaction at
// --------  ---------  ---------------------------------------  ------------------------
// command   in         start_i, busy_o, operation_i, entry_*_i,  start_i && !busy_o
//                      cell_*_i
// result    out        done_o, nearest_index_o                  every cycle done_o is high
// config    in/out     psel, penable, pwrite, paddr, pwdata,     psel&penable&pwrite&pready
//                      prdata, pready
//
// A load is written to the palette as the back end pops it. A query holds
// the back end from its pop through the scan, n = min(color_count,
// PALETTE_DEPTH) palette reads at one per cycle from the single RAM port,
// until the square and compare stages drain. A count of zero answers
// without a scan.
// rst_ni is asynchronous, active low; the palette RAM is not cleared and
// needs no sweep. busy_o is high only while the two-entry command queue is
// full. The result channel has no backpressure.
module nearest_palette_color_search
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned RED_CELLS     = 32,
  parameter int unsigned GREEN_CELLS   = 64,
  parameter int unsigned BLUE_CELLS    = 16,
  parameter int unsigned BIN_COUNT     = 16,
  parameter int unsigned BIN_SHIFT     = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  input  logic [4:0]  cell_red_i,
  input  logic [5:0]  cell_green_i,
  input  logic [3:0]  cell_blue_i,
  // result
  output logic        done_o,
  output logic [7:0]  nearest_index_o,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // color_count register, word 0. Low address bits are byte offsets.
  logic [COUNT_W-1:0] color_count_q;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(color_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= COUNT_W'(256);
    end else if (cfg_write) begin
      color_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // Front: scales cells, drops out-of-range loads, queues the rest
  queue_head_t head;
  logic        pop;

  npcs_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .RED_CELLS     (RED_CELLS),
    .GREEN_CELLS   (GREEN_CELLS),
    .BLUE_CELLS    (BLUE_CELLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .entry_red_i   (entry_red_i),
    .entry_green_i (entry_green_i),
    .entry_blue_i  (entry_blue_i),
    .cell_red_i    (cell_red_i),
    .cell_green_i  (cell_green_i),
    .cell_blue_i   (cell_blue_i),
    .pop_i         (pop),
    .head_o        (head)
  );

  // Back: palette writes and the scan
  npcs_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .BIN_COUNT     (BIN_COUNT),
    .BIN_SHIFT     (BIN_SHIFT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .color_count_i   (color_count_q),
    .done_o          (done_o),
    .nearest_index_o (nearest_index_o)
  );

endmodule

/* hw/rtl/npcs_checker.sv */
module npcs_checker #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy_o,
  input logic        done_o,
  input logic [7:0]  nearest_index_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // A reported index always names a real palette slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, nearest_index_o} < 9'(PALETTE_DEPTH)))
    else $error("nearest index beyond palette depth");

  // A color_count write reads back on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr == 3'd0)) |=>
      (paddr != 3'd0) || (prdata[8:0] == $past(pwdata[8:0])))
    else $error("color_count readback mismatch");

  // Unused register bits read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:9] == 23'd0)
    else $error("prdata upper bits set");

  // Queue is empty right after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !busy_o)
    else $error("busy after reset");

endmodule

bind nearest_palette_color_search npcs_checker #(
  .PALETTE_DEPTH (PALETTE_DEPTH)
) u_npcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .nearest_index_o (nearest_index_o),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);

/* test/testbench.sv */
// Nearest palette color search: loads palette entries, issues color cube
// queries and checks each returned index against a predictor kept in step
// with every accepted transaction. color_count is rewritten between phases
// while the block is idle.
module testbench;
  import npcs_pkg::*;

  localparam logic [2:0]  COLOR_COUNT_ADDR = 3'd0;
  localparam int unsigned DEPTH            = 256;
  localparam int unsigned RED_CELLS        = 32;
  localparam int unsigned GREEN_CELLS      = 64;
  localparam int unsigned BLUE_CELLS       = 16;
  localparam int unsigned BIN_LAST         = 15;
  localparam int unsigned BIN_SHIFT        = 11;
  // a load leaves the back end as it is popped, queue holds two: plenty of margin
  localparam int unsigned DRAIN_CYCLES     = 16;
  // searches run one after another, at most three searches in flight
  localparam int unsigned SETTLE_LIMIT     = 4000;
  localparam int unsigned PHASE_ITEMS      = 210;
  localparam int unsigned LOAD_PCT         = 40;

  typedef struct packed {
    logic       op;
    logic [7:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] cell_red;
    logic [5:0] cell_green;
    logic [3:0] cell_blue;
  } command_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Palette mirror plus queue of expected nearest indices
  class palette_search_model;
    rgb_t        palette [DEPTH];
    logic [8:0]  color_count;
    logic [7:0]  expected_indices [$];
    int unsigned mismatches;
    int unsigned answers;
    int unsigned loads;
    int unsigned queries;

    function new();
      foreach (palette[i]) palette[i] = '0;
      color_count = 9'd256;
      mismatches  = 0;
      answers     = 0;
      loads       = 0;
      queries     = 0;
    endfunction

    static function int unsigned scale(int unsigned cell_idx, int unsigned cells);
      int unsigned c;
      c = (cell_idx > cells - 1) ? cells - 1 : cell_idx;
      return (FULL_LEVEL * c) / (cells - 1);
    endfunction

    static function int unsigned sq_diff(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    // Least total squared distance; ties to lower red+blue bin, then lower index
    function logic [7:0] nearest(command_t c);
      int unsigned lr, lg, lb, n, rb, bin, total;
      int unsigned best_dist, best_bin, best_index;
      bit          have;
      lr = scale(c.cell_red, RED_CELLS);
      lg = scale(c.cell_green, GREEN_CELLS);
      lb = scale(c.cell_blue, BLUE_CELLS);
      n  = (color_count > DEPTH) ? DEPTH : color_count;
      best_dist  = 0;
      best_bin   = 0;
      best_index = 0;
      have       = 0;
      for (int unsigned i = 0; i < n; i++) begin
        rb    = sq_diff(palette[i].red, lr) + sq_diff(palette[i].blue, lb);
        bin   = rb >> BIN_SHIFT;
        if (bin > BIN_LAST) bin = BIN_LAST;
        total = rb + sq_diff(palette[i].green, lg);
        if (!have || total < best_dist || (total == best_dist && bin < best_bin)) begin
          have       = 1;
          best_dist  = total;
          best_bin   = bin;
          best_index = i;
        end
      end
      return best_index[7:0];
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void note_command(command_t c);
      if (c.op == OP_LOAD) begin
        palette[c.slot] = '{c.red, c.green, c.blue};
        loads++;
      end else begin
        expected_indices.push_back(nearest(c));
        queries++;
      end
    endfunction

    task check_answer(logic [7:0] got);
      logic [7:0] want;
      if (expected_indices.size() == 0) begin
        report($sformatf("nearest_index %0d with no search pending", got));
        return;
      end
      want = expected_indices.pop_front();
      answers++;
      if (got !== want)
        report($sformatf("search %0d: nearest_index %0d, expected %0d",
                         answers, got, want));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        operation_i;
  logic [7:0]  entry_index_i;
  logic [7:0]  entry_red_i;
  logic [7:0]  entry_green_i;
  logic [7:0]  entry_blue_i;
  logic [4:0]  cell_red_i;
  logic [5:0]  cell_green_i;
  logic [3:0]  cell_blue_i;
  logic        done_o;
  logic [7:0]  nearest_index_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  palette_search_model board;
  int unsigned         idle_pct;
  int unsigned         settings_seen;

  nearest_palette_color_search uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .entry_red_i    (entry_red_i),
    .entry_green_i  (entry_green_i),
    .entry_blue_i   (entry_blue_i),
    .cell_red_i     (cell_red_i),
    .cell_green_i   (cell_green_i),
    .cell_blue_i    (cell_blue_i),
    .done_o         (done_o),
    .nearest_index_o(nearest_index_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // Result channel has no backpressure: every done_o cycle is a transaction.
  // Sampled at the edge, so values are the ones held during the ending cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_answer(nearest_index_o);
  end

  // Hold start_i low for a random number of cycles, then present the command
  // until an edge sees start_i && !busy_o. Prediction follows acceptance order.
  task automatic send_command(input command_t c);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    operation_i   <= c.op;
    entry_index_i <= c.slot;
    entry_red_i   <= c.red;
    entry_green_i <= c.green;
    entry_blue_i  <= c.blue;
    cell_red_i    <= c.cell_red;
    cell_green_i  <= c.cell_green;
    cell_blue_i   <= c.cell_blue;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_command(c);
  endtask

  // Wait for every pending search to answer, then let trailing loads retire
  task automatic settle();
    int unsigned waited;
    waited = 0;
    start_i <= 1'b0;
    while (board.expected_indices.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (board.expected_indices.size() != 0) begin
      board.report($sformatf("%0d searches never answered",
                             board.expected_indices.size()));
      board.expected_indices.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_color_count(input logic [8:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COLOR_COUNT_ADDR;
    pwdata  <= {23'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.color_count = value;
    settings_seen++;
  endtask

  function automatic command_t make_load(int unsigned slot, int unsigned r,
                                         int unsigned g, int unsigned b);
    command_t c;
    c       = command_t'({$urandom, $urandom});
    c.op    = OP_LOAD;
    c.slot  = slot[7:0];
    c.red   = r[7:0];
    c.green = g[7:0];
    c.blue  = b[7:0];
    return c;
  endfunction

  function automatic command_t make_query(int unsigned cr, int unsigned cg,
                                          int unsigned cb);
    command_t c;
    c            = command_t'({$urandom, $urandom});
    c.op         = OP_QUERY;
    c.cell_red   = cr[4:0];
    c.cell_green = cg[5:0];
    c.cell_blue  = cb[3:0];
    return c;
  endfunction

  // Loads favor coarse levels and copies of existing entries so that
  // equal distances, and with them both tie-break rules, come up often.
  function automatic command_t random_command(int unsigned load_pct);
    command_t    c;
    int unsigned coarse [7] = '{0, 64, 85, 128, 170, 192, 255};
    c    = command_t'({$urandom, $urandom});
    c.op = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_QUERY;
    if (c.op == OP_LOAD) begin
      case ($urandom_range(3))
        0: begin
          c.red   = 8'(coarse[$urandom_range(6)]);
          c.green = 8'(coarse[$urandom_range(6)]);
          c.blue  = 8'(coarse[$urandom_range(6)]);
        end
        1: begin
          {c.red, c.green, c.blue} = board.palette[$urandom_range(DEPTH - 1)];
        end
        default: begin
        end
      endcase
    end
    return c;
  endfunction

  initial begin
    int unsigned idle_modes [3] = '{0, 74, 7};
    logic [8:0]  phase_counts [8] = '{9'd256, 9'd511, 9'd1, 9'd257,
                                      9'd2, 9'd0, 9'd16, 9'd255};
    logic [8:0]  count;

    board         = new();
    idle_pct      = 0;
    settings_seen = 0;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    operation_i   <= OP_LOAD;
    entry_index_i <= '0;
    entry_red_i   <= '0;
    entry_green_i <= '0;
    entry_blue_i  <= '0;
    cell_red_i    <= '0;
    cell_green_i  <= '0;
    cell_blue_i   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty search: nothing is read, answer is index 0
    write_color_count(9'd0);
    send_command(make_query(0, 0, 0));
    send_command(make_query(31, 63, 15));
    settle();

    // Three entries at equal distance from black: slot 0 sits in a higher
    // red+blue bin, slots 1 and 2 tie completely -> slot 1 wins
    write_color_count(9'd3);
    send_command(make_load(0, 64, 0, 0));
    send_command(make_load(1, 0, 64, 0));
    send_command(make_load(2, 0, 64, 0));
    send_command(make_load(255, 255, 255, 255));
    send_command(make_query(0, 0, 0));
    // white: slots 0 and 1 tie in total and in the clipped top bin
    send_command(make_query(31, 63, 15));
    send_command(make_load(0, 0, 0, 0));
    send_command(make_query(0, 0, 0));
    send_command(make_query(16, 32, 8));
    settle();

    // Single entry: always index 0
    write_color_count(9'd1);
    send_command(make_query(31, 0, 15));
    send_command(make_query(0, 63, 0));
    settle();

    // Fill the whole palette so every later count only reads written slots
    write_color_count(9'd256);
    for (int unsigned i = 0; i < DEPTH; i++) begin
      command_t c;
      c      = random_command(100);
      c.slot = i[7:0];
      send_command(c);
    end
    settle();

    for (int unsigned k = 0; k < 8; k++) begin
      count = phase_counts[k];
      if (count == 9'd0) count = 9'($urandom_range(1, DEPTH));
      write_color_count(count);
      idle_pct = idle_modes[k % 3];
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) send_command(random_command(LOAD_PCT));
      settle();
    end

    $display("run covered %0d palette loads and %0d searches under %0d color_count settings",
             board.loads, board.queries, settings_seen);
    $display("%0d answers checked, %0d mismatches", board.answers, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
